>>> hdl/ilt_pkg.sv
// ============================================================================
// ilt_pkg: shared definitions for the IRC line tokenizer
// Holds the parse phases, record kinds, delimiter bytes and sizing constants.
// ============================================================================
package ilt_pkg;

  parameter int MAX_LINE_BYTES = 8192;
  parameter int QUEUE_DEPTH    = 4;
  parameter int IDX_W          = 8;

  localparam logic [IDX_W-1:0] IDX_MAX = '1;

  localparam logic [7:0] CH_AT    = 8'h40;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_COLON = 8'h3A;

  typedef enum logic [2:0] {
    KIND_TAG      = 3'd0,
    KIND_PREFIX   = 3'd1,
    KIND_COMMAND  = 3'd2,
    KIND_PARAM    = 3'd3,
    KIND_TRAILING = 3'd4,
    KIND_EOL      = 3'd5
  } kind_t;

  typedef enum logic [3:0] {
    PH_LINE_START   = 4'd0,
    PH_TAG_START    = 4'd1,
    PH_KEY          = 4'd2,
    PH_VALUE        = 4'd3,
    PH_PREFIX_CHECK = 4'd4,
    PH_PREFIX       = 4'd5,
    PH_CMD_START    = 4'd6,
    PH_CMD          = 4'd7,
    PH_PARAM_START  = 4'd8,
    PH_PARAM        = 4'd9,
    PH_COLON        = 4'd10,
    PH_TRAILING     = 4'd11
  } phase_t;

  // Which records one accepted byte produced and the kind of the token record.
  typedef struct packed {
    logic  tok_v;
    logic  eol_v;
    kind_t kind;
  } ilt_flags_t;

endpackage

>>> hdl/ilt_parser.sv
// ============================================================================
// ilt_parser: front end of the IRC line tokenizer
// Accepts one byte per cycle while the queue has space, tracks the parse
// phase and builds the token and end-of-line records that the byte causes.
// ============================================================================
module ilt_parser #(
  parameter int MAX_LINE_BYTES = ilt_pkg::MAX_LINE_BYTES,
  parameter int START_W        = $clog2(MAX_LINE_BYTES),
  parameter int POS_W          = $clog2(MAX_LINE_BYTES + 1)
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic                      in_space,
  input  logic [7:0]                in_byte,
  input  logic                      in_last,
  output logic                      push,
  output ilt_pkg::ilt_flags_t       rec_flags,
  output logic [START_W-1:0]        rec_start,
  output logic [POS_W-1:0]          rec_length,
  output logic                      rec_val_present,
  output logic [START_W-1:0]        rec_val_start,
  output logic [POS_W-1:0]          rec_val_length,
  output logic [ilt_pkg::IDX_W-1:0] rec_index,
  output logic                      rec_overflow,
  output logic [POS_W-1:0]          eol_length,
  output logic [ilt_pkg::IDX_W-1:0] eol_index
);

  localparam logic [POS_W-1:0]   MAX_POS   = POS_W'(MAX_LINE_BYTES);
  localparam logic [START_W-1:0] MAX_START = START_W'(MAX_LINE_BYTES - 1);

  ilt_pkg::phase_t phase_r, phase_nxt, phase_w, ph;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [POS_W-1:0] ots_r, ots_nxt, ots_w;
  logic [POS_W-1:0] ovs_r, ovs_nxt, ovs_w;
  logic             hv_r, hv_nxt, hv_w;
  logic [ilt_pkg::IDX_W-1:0] tag_cnt_r, tag_cnt_nxt, tag_w;
  logic [ilt_pkg::IDX_W-1:0] par_cnt_r, par_cnt_nxt, par_w;
  logic             ovf_r, ovf_nxt;

  logic             accept, sat, stop;
  logic [POS_W-1:0] cur, nxt;
  logic             close_v;
  ilt_pkg::kind_t   close_kind;
  logic [POS_W-1:0] close_end, start_eff, key_end, vs_full;
  logic             has_val;
  logic             is_at, is_sp, is_eq, is_semi, is_colon;

  function automatic logic [POS_W-1:0] after_pos(input logic [POS_W-1:0] s);
    after_pos = (s == MAX_POS) ? s : s + POS_W'(1);
  endfunction

  function automatic logic [START_W-1:0] clamp_pos(input logic [POS_W-1:0] s);
    clamp_pos = (s == MAX_POS) ? MAX_START : s[START_W-1:0];
  endfunction

  assign accept   = in_valid & in_space;
  assign sat      = (pos_r == MAX_POS);
  assign cur      = pos_r;
  assign nxt      = sat ? pos_r : pos_r + POS_W'(1);
  assign is_at    = (in_byte == ilt_pkg::CH_AT);
  assign is_sp    = (in_byte == ilt_pkg::CH_SPACE);
  assign is_eq    = (in_byte == ilt_pkg::CH_EQ);
  assign is_semi  = (in_byte == ilt_pkg::CH_SEMI);
  assign is_colon = (in_byte == ilt_pkg::CH_COLON);

  always_comb begin
    ph         = phase_r;
    stop       = 1'b0;
    phase_w    = phase_r;
    ots_w      = ots_r;
    ovs_w      = ovs_r;
    hv_w       = hv_r;
    close_v    = 1'b0;
    close_kind = ilt_pkg::KIND_TAG;
    close_end  = cur;

    if (ph == ilt_pkg::PH_LINE_START) begin
      if (is_at) begin
        phase_w = ilt_pkg::PH_TAG_START;
        stop    = 1'b1;
      end else begin
        ph = ilt_pkg::PH_PREFIX_CHECK;
      end
    end
    if (!stop && ph == ilt_pkg::PH_TAG_START) begin
      if (is_sp) begin
        phase_w = ilt_pkg::PH_PREFIX_CHECK;
        stop    = 1'b1;
      end else begin
        ots_w = cur;
        hv_w  = 1'b0;
        ovs_w = '0;
        ph    = ilt_pkg::PH_KEY;
      end
    end
    if (!stop && ph == ilt_pkg::PH_PREFIX_CHECK) begin
      if (is_colon) begin
        ots_w   = nxt;
        phase_w = ilt_pkg::PH_PREFIX;
        stop    = 1'b1;
      end else begin
        ots_w = cur;
        ph    = ilt_pkg::PH_CMD;
      end
    end
    if (!stop && ph == ilt_pkg::PH_CMD_START) begin
      ots_w = cur;
      ph    = ilt_pkg::PH_CMD;
    end

    if (!stop) begin
      phase_w = ph;
      unique case (ph)
        ilt_pkg::PH_KEY: begin
          if (is_eq) begin
            ovs_w   = cur;
            hv_w    = 1'b1;
            phase_w = ilt_pkg::PH_VALUE;
          end else if (is_semi || is_sp) begin
            close_v = 1'b1;
            phase_w = is_semi ? ilt_pkg::PH_TAG_START : ilt_pkg::PH_PREFIX_CHECK;
          end
        end
        ilt_pkg::PH_VALUE: begin
          if (is_semi || is_sp) begin
            close_v = 1'b1;
            phase_w = is_semi ? ilt_pkg::PH_TAG_START : ilt_pkg::PH_PREFIX_CHECK;
          end
        end
        ilt_pkg::PH_PREFIX: begin
          if (is_sp) begin
            close_v    = 1'b1;
            close_kind = ilt_pkg::KIND_PREFIX;
            phase_w    = ilt_pkg::PH_CMD_START;
          end
        end
        ilt_pkg::PH_CMD: begin
          if (is_sp) begin
            close_v    = 1'b1;
            close_kind = ilt_pkg::KIND_COMMAND;
            phase_w    = ilt_pkg::PH_PARAM_START;
          end
        end
        ilt_pkg::PH_PARAM_START: begin
          ots_w = cur;
          if (is_colon) begin
            phase_w = ilt_pkg::PH_COLON;
          end else if (is_sp) begin
            close_v    = 1'b1;
            close_kind = ilt_pkg::KIND_PARAM;
          end else begin
            phase_w = ilt_pkg::PH_PARAM;
          end
        end
        ilt_pkg::PH_PARAM: begin
          if (is_sp) begin
            close_v    = 1'b1;
            close_kind = ilt_pkg::KIND_PARAM;
            phase_w    = ilt_pkg::PH_PARAM_START;
          end
        end
        ilt_pkg::PH_COLON: begin
          phase_w = ilt_pkg::PH_TRAILING;
        end
        default: begin
        end
      endcase
    end

    // A byte that closes a token leaves a phase with nothing open, so the
    // end-of-line close below never meets a token closed above.
    if (in_last) begin
      if (!close_v) close_end = nxt;
      unique case (phase_w)
        ilt_pkg::PH_KEY, ilt_pkg::PH_VALUE: begin
          close_v    = 1'b1;
          close_kind = ilt_pkg::KIND_TAG;
        end
        ilt_pkg::PH_PREFIX: begin
          close_v    = 1'b1;
          close_kind = ilt_pkg::KIND_PREFIX;
        end
        ilt_pkg::PH_CMD: begin
          close_v    = 1'b1;
          close_kind = ilt_pkg::KIND_COMMAND;
        end
        ilt_pkg::PH_PARAM, ilt_pkg::PH_COLON: begin
          close_v    = 1'b1;
          close_kind = ilt_pkg::KIND_PARAM;
        end
        ilt_pkg::PH_TRAILING: begin
          close_v    = 1'b1;
          close_kind = ilt_pkg::KIND_TRAILING;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    has_val   = (close_kind == ilt_pkg::KIND_TAG) && hv_w;
    start_eff = (close_kind == ilt_pkg::KIND_TRAILING) ? after_pos(ots_w) : ots_w;
    key_end   = has_val ? ovs_w : close_end;
    vs_full   = has_val ? after_pos(ovs_w) : '0;

    rec_flags.tok_v = close_v;
    rec_flags.eol_v = in_last;
    rec_flags.kind  = close_kind;
    rec_start       = clamp_pos(start_eff);
    rec_length      = key_end - start_eff;
    rec_val_present = has_val;
    rec_val_start   = has_val ? clamp_pos(vs_full) : '0;
    rec_val_length  = has_val ? close_end - vs_full : '0;
    rec_overflow    = ovf_r | sat;

    tag_w = tag_cnt_r;
    par_w = par_cnt_r;
    rec_index = '0;
    if (close_v && close_kind == ilt_pkg::KIND_TAG) begin
      rec_index = tag_cnt_r;
      if (tag_cnt_r != ilt_pkg::IDX_MAX) tag_w = tag_cnt_r + ilt_pkg::IDX_W'(1);
    end
    if (close_v && close_kind == ilt_pkg::KIND_PARAM) begin
      rec_index = par_cnt_r;
      if (par_cnt_r != ilt_pkg::IDX_MAX) par_w = par_cnt_r + ilt_pkg::IDX_W'(1);
    end
    eol_length = nxt;
    eol_index  = par_w;

    push = accept & (close_v | in_last);

    if (in_last) begin
      phase_nxt   = ilt_pkg::PH_LINE_START;
      pos_nxt     = '0;
      ots_nxt     = '0;
      ovs_nxt     = '0;
      hv_nxt      = 1'b0;
      tag_cnt_nxt = '0;
      par_cnt_nxt = '0;
      ovf_nxt     = 1'b0;
    end else begin
      phase_nxt   = phase_w;
      pos_nxt     = nxt;
      ots_nxt     = ots_w;
      ovs_nxt     = ovs_w;
      hv_nxt      = hv_w;
      tag_cnt_nxt = tag_w;
      par_cnt_nxt = par_w;
      ovf_nxt     = ovf_r | sat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= ilt_pkg::PH_LINE_START;
      pos_r     <= '0;
      ots_r     <= '0;
      ovs_r     <= '0;
      hv_r      <= 1'b0;
      tag_cnt_r <= '0;
      par_cnt_r <= '0;
      ovf_r     <= 1'b0;
    end else if (accept) begin
      phase_r   <= phase_nxt;
      pos_r     <= pos_nxt;
      ots_r     <= ots_nxt;
      ovs_r     <= ovs_nxt;
      hv_r      <= hv_nxt;
      tag_cnt_r <= tag_cnt_nxt;
      par_cnt_r <= par_cnt_nxt;
      ovf_r     <= ovf_nxt;
    end
  end

endmodule

>>> hdl/ilt_queue.sv
// ============================================================================
// ilt_queue: record queue of the IRC line tokenizer
// A small first-in first-out buffer that decouples the parser from the
// output stage.
// ============================================================================
module ilt_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = ilt_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             not_empty,
  output logic             not_full
);

  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam logic [ADDR_W-1:0] LAST = ADDR_W'(DEPTH - 1);

  logic [WIDTH-1:0]  mem_r [DEPTH];
  logic [ADDR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [ADDR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              do_wr, do_rd;

  assign not_empty = (count_r != '0);
  assign not_full  = (count_r != CNT_W'(DEPTH));
  assign do_wr     = wr_en & not_full;
  assign do_rd     = rd_en & not_empty;
  assign rd_data   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_wr ? ((wr_ptr_r == LAST) ? '0 : wr_ptr_r + ADDR_W'(1)) : wr_ptr_r;
    rd_ptr_nxt = do_rd ? ((rd_ptr_r == LAST) ? '0 : rd_ptr_r + ADDR_W'(1)) : rd_ptr_r;
    count_nxt  = count_r + CNT_W'(do_wr) - CNT_W'(do_rd);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

>>> hdl/ilt_emitter.sv
// ============================================================================
// ilt_emitter: back end of the IRC line tokenizer
// Takes queued records, sends the token record and then the end-of-line
// record, and holds each result in an output register until it is taken.
// ============================================================================
module ilt_emitter #(
  parameter int START_W    = 13,
  parameter int POS_W      = 14,
  parameter int OUT_DATA_W = 64
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      q_valid,
  output logic                      q_pop,
  input  ilt_pkg::ilt_flags_t       rec_flags,
  input  logic [START_W-1:0]        rec_start,
  input  logic [POS_W-1:0]          rec_length,
  input  logic                      rec_val_present,
  input  logic [START_W-1:0]        rec_val_start,
  input  logic [POS_W-1:0]          rec_val_length,
  input  logic [ilt_pkg::IDX_W-1:0] rec_index,
  input  logic                      rec_overflow,
  input  logic [POS_W-1:0]          eol_length,
  input  logic [ilt_pkg::IDX_W-1:0] eol_index,
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [OUT_DATA_W-1:0]     out_tdata,
  output logic [2:0]                out_tuser,
  output logic                      out_tlast
);

  logic                  valid_r, valid_nxt;
  logic                  half_r, half_nxt;
  logic [OUT_DATA_W-1:0] data_r, data_nxt;
  ilt_pkg::kind_t        kind_r, kind_nxt;
  logic                  last_r, last_nxt;
  logic                  load, send_tok;

  assign load     = q_valid & (~valid_r | out_tready);
  assign send_tok = rec_flags.tok_v & ~half_r;

  always_comb begin
    valid_nxt = valid_r & ~out_tready;
    half_nxt  = half_r;
    data_nxt  = data_r;
    kind_nxt  = kind_r;
    last_nxt  = last_r;
    q_pop     = 1'b0;
    if (load) begin
      valid_nxt = 1'b1;
      if (send_tok) begin
        data_nxt = OUT_DATA_W'({rec_overflow, rec_index, rec_val_length, rec_val_start,
                                rec_val_present, rec_length, rec_start});
        kind_nxt = rec_flags.kind;
        last_nxt = 1'b0;
        half_nxt = rec_flags.eol_v;
        q_pop    = ~rec_flags.eol_v;
      end else begin
        data_nxt = OUT_DATA_W'({rec_overflow, eol_index, POS_W'(0), START_W'(0),
                                1'b0, eol_length, START_W'(0)});
        kind_nxt = ilt_pkg::KIND_EOL;
        last_nxt = 1'b1;
        half_nxt = 1'b0;
        q_pop    = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      half_r  <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      half_r  <= half_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    kind_r <= kind_nxt;
    last_r <= last_nxt;
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = data_r;
  assign out_tuser  = kind_r;
  assign out_tlast  = last_r;

endmodule

>>> hdl/irc_line_tokenizer_unit.sv
// ============================================================================
// irc_line_tokenizer_unit: streaming IRC message line tokenizer
// Splits a message line, one byte per transaction, into tag, prefix,
// command, parameter and trailing records followed by an end-of-line record.
// ============================================================================
// The block takes one line byte per clock cycle while in_tready is high. The
// parser decides the phase and the records of a byte in the cycle it accepts it
// and writes them into a four-entry queue at the accepting edge; the output
// register loads the oldest record, so a record reaches out_* only through the
// queue and that register. Most bytes cause no record or one record; the last
// byte of a line causes up to two (a closed token and the end-of-line record),
// and the output stage sends one record per cycle while out_tready is high, so
// in_tready drops when the queue fills: when the result side stalls, or when
// short lines end so close together that their two-record last bytes outrun
// the output stage. Offsets stop at MAX_LINE_BYTES and set line_overflow.
module irc_line_tokenizer_unit #(
  parameter int MAX_LINE_BYTES = ilt_pkg::MAX_LINE_BYTES,
  parameter int START_W        = $clog2(MAX_LINE_BYTES),
  parameter int POS_W          = $clog2(MAX_LINE_BYTES + 1),
  parameter int OUT_DATA_W     = ((2 * START_W + 2 * POS_W + ilt_pkg::IDX_W + 2 + 7) / 8) * 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,   // line_byte
  input  logic                  in_tlast,   // final_byte
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // token_start, token_length, value_present, value_start, value_length,
  // token_index, line_overflow, zero fill
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic [2:0]            out_tuser,  // token_kind
  output logic                  out_tlast   // end_of_line
);

  localparam int Q_W = $bits(ilt_pkg::ilt_flags_t) + 2 * START_W + 3 * POS_W
                       + 2 * ilt_pkg::IDX_W + 2;

  logic                      push, q_pop, q_valid, q_space;
  logic [Q_W-1:0]            q_wr, q_rd;

  ilt_pkg::ilt_flags_t       p_flags, e_flags;
  logic [START_W-1:0]        p_start, e_start, p_vstart, e_vstart;
  logic [POS_W-1:0]          p_len, e_len, p_vlen, e_vlen, p_eol_len, e_eol_len;
  logic                      p_vp, e_vp, p_ovf, e_ovf;
  logic [ilt_pkg::IDX_W-1:0] p_idx, e_idx, p_eol_idx, e_eol_idx;

  assign in_tready = q_space;

  ilt_parser #(
    .MAX_LINE_BYTES (MAX_LINE_BYTES),
    .START_W        (START_W),
    .POS_W          (POS_W)
  ) u_parser (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_tvalid),
    .in_space        (q_space),
    .in_byte         (in_tdata),
    .in_last         (in_tlast),
    .push            (push),
    .rec_flags       (p_flags),
    .rec_start       (p_start),
    .rec_length      (p_len),
    .rec_val_present (p_vp),
    .rec_val_start   (p_vstart),
    .rec_val_length  (p_vlen),
    .rec_index       (p_idx),
    .rec_overflow    (p_ovf),
    .eol_length      (p_eol_len),
    .eol_index       (p_eol_idx)
  );

  assign q_wr = {p_flags, p_start, p_len, p_vp, p_vstart, p_vlen, p_idx, p_ovf,
                 p_eol_len, p_eol_idx};

  ilt_queue #(
    .WIDTH (Q_W),
    .DEPTH (ilt_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     (push),
    .wr_data   (q_wr),
    .rd_en     (q_pop),
    .rd_data   (q_rd),
    .not_empty (q_valid),
    .not_full  (q_space)
  );

  assign {e_flags, e_start, e_len, e_vp, e_vstart, e_vlen, e_idx, e_ovf,
          e_eol_len, e_eol_idx} = q_rd;

  ilt_emitter #(
    .START_W    (START_W),
    .POS_W      (POS_W),
    .OUT_DATA_W (OUT_DATA_W)
  ) u_emitter (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_pop           (q_pop),
    .rec_flags       (e_flags),
    .rec_start       (e_start),
    .rec_length      (e_len),
    .rec_val_present (e_vp),
    .rec_val_start   (e_vstart),
    .rec_val_length  (e_vlen),
    .rec_index       (e_idx),
    .rec_overflow    (e_ovf),
    .eol_length      (e_eol_len),
    .eol_index       (e_eol_idx),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .out_tuser       (out_tuser),
    .out_tlast       (out_tlast)
  );

  localparam int VP_BIT = START_W + POS_W;

  a_last_is_eol: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tlast == (out_tuser == ilt_pkg::KIND_EOL)))
    else $error("End-of-frame flag disagrees with the record kind.");

  a_eol_no_start: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tlast) |-> (out_tdata[START_W-1:0] == '0 && !out_tdata[VP_BIT]))
    else $error("End-of-line record carries a start offset or a value.");

  a_value_only_tags: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser != ilt_pkg::KIND_TAG) |-> !out_tdata[VP_BIT])
    else $error("Value span reported on a record that is not a tag.");

  a_no_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tdata[VP_BIT]) |->
      (out_tdata[VP_BIT+START_W+POS_W:VP_BIT+1] == '0))
    else $error("Absent value has a nonzero span.");

endmodule

>>> test/irc_line_tokenizer_unit_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// irc_line_tokenizer_unit_tb: self-checking bench for the IRC line tokenizer
// Feeds message lines one byte per transaction, predicts every token record
// and compares each received record with the oldest prediction, under random
// gaps, stalls and one long receiver hold-off.
// ============================================================================
module irc_line_tokenizer_unit_tb;

  localparam int LINE_MAX = ilt_pkg::MAX_LINE_BYTES;
  localparam int WATCHDOG_CYCLES = 4000;

  typedef struct packed {
    ilt_pkg::kind_t kind;
    logic [12:0]    start;
    logic [13:0]    len;
    logic           vp;
    logic [12:0]    vstart;
    logic [13:0]    vlen;
    logic [7:0]     idx;
    logic           ovf;
    logic           eol;
  } token_rec_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } line_byte_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;
  logic [2:0]  out_tuser;
  logic        out_tlast;

  irc_line_tokenizer_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  line_byte_t feed_q[$];
  logic [7:0] line_buf[$];
  token_rec_t expected_tokens[$];
  line_byte_t next_byte;

  bit in_fire = 1'b0;
  int quiet_cycles = 0;
  int err_count = 0;
  int tx_wait = 0;
  int rx_stall = 0;
  int rx_hold_req = 0;
  bit tx_burst = 1'b0;
  bit rx_burst = 1'b0;

  ilt_pkg::phase_t tk_phase = ilt_pkg::PH_LINE_START;
  int tk_pos = 0;
  int tk_start = 0;
  int tk_vstart = 0;
  bit tk_has_val = 1'b0;
  int tk_tags = 0;
  int tk_params = 0;
  bit tk_ovf = 1'b0;

  string word_chars = "abcdefghijklmnopqrstuvwxyzABCXYZ0123456789!#.-_[]";

  function automatic int clamp_pos(int s);
    return (s >= LINE_MAX) ? LINE_MAX - 1 : s;
  endfunction

  function automatic int after_pos(int s);
    return (s < LINE_MAX) ? s + 1 : LINE_MAX;
  endfunction

  function automatic void add_token(ilt_pkg::kind_t k, int s, int len, bit vp, int vs,
                                    int vl, int idx, bit eol);
    token_rec_t rec;
    rec.kind   = k;
    rec.start  = 13'(clamp_pos(s));
    rec.len    = 14'(len);
    rec.vp     = vp;
    rec.vstart = vp ? 13'(clamp_pos(vs)) : 13'd0;
    rec.vlen   = 14'(vl);
    rec.idx    = 8'(idx);
    rec.ovf    = tk_ovf;
    rec.eol    = eol;
    expected_tokens.push_back(rec);
  endfunction

  function automatic void close_tag(int stop);
    int key_end;
    int vs;
    int vl;
    key_end = tk_has_val ? tk_vstart : stop;
    vs = tk_has_val ? after_pos(tk_vstart) : 0;
    vl = tk_has_val ? stop - vs : 0;
    add_token(ilt_pkg::KIND_TAG, tk_start, key_end - tk_start, tk_has_val, vs, vl,
              tk_tags, 1'b0);
    if (tk_tags < 255) tk_tags++;
  endfunction

  function automatic void close_param(int s, int len);
    add_token(ilt_pkg::KIND_PARAM, s, len, 1'b0, 0, 0, tk_params, 1'b0);
    if (tk_params < 255) tk_params++;
  endfunction

  function automatic void predict_tokens(logic [7:0] c, logic fin);
    int cur;
    int nxt;
    int stop;
    int ts;
    bit again;
    cur = tk_pos;
    if (cur >= LINE_MAX) begin
      tk_ovf = 1'b1;
      cur = LINE_MAX;
      nxt = LINE_MAX;
    end else begin
      nxt = cur + 1;
    end
    tk_pos = nxt;
    again = 1'b1;
    while (again) begin
      again = 1'b0;
      case (tk_phase)
        ilt_pkg::PH_LINE_START: begin
          if (c == ilt_pkg::CH_AT) begin
            tk_phase = ilt_pkg::PH_TAG_START;
          end else begin
            tk_phase = ilt_pkg::PH_PREFIX_CHECK;
            again = 1'b1;
          end
        end
        ilt_pkg::PH_TAG_START: begin
          if (c == ilt_pkg::CH_SPACE) begin
            tk_phase = ilt_pkg::PH_PREFIX_CHECK;
          end else begin
            tk_start = cur;
            tk_has_val = 1'b0;
            tk_vstart = 0;
            tk_phase = ilt_pkg::PH_KEY;
            again = 1'b1;
          end
        end
        ilt_pkg::PH_KEY: begin
          if (c == ilt_pkg::CH_EQ) begin
            tk_vstart = cur;
            tk_has_val = 1'b1;
            tk_phase = ilt_pkg::PH_VALUE;
          end else if (c == ilt_pkg::CH_SEMI) begin
            close_tag(cur);
            tk_phase = ilt_pkg::PH_TAG_START;
          end else if (c == ilt_pkg::CH_SPACE) begin
            close_tag(cur);
            tk_phase = ilt_pkg::PH_PREFIX_CHECK;
          end
        end
        ilt_pkg::PH_VALUE: begin
          if (c == ilt_pkg::CH_SEMI) begin
            close_tag(cur);
            tk_phase = ilt_pkg::PH_TAG_START;
          end else if (c == ilt_pkg::CH_SPACE) begin
            close_tag(cur);
            tk_phase = ilt_pkg::PH_PREFIX_CHECK;
          end
        end
        ilt_pkg::PH_PREFIX_CHECK: begin
          if (c == ilt_pkg::CH_COLON) begin
            tk_start = nxt;
            tk_phase = ilt_pkg::PH_PREFIX;
          end else begin
            tk_start = cur;
            tk_phase = ilt_pkg::PH_CMD;
            again = 1'b1;
          end
        end
        ilt_pkg::PH_PREFIX: begin
          if (c == ilt_pkg::CH_SPACE) begin
            add_token(ilt_pkg::KIND_PREFIX, tk_start, cur - tk_start, 1'b0, 0, 0, 0, 1'b0);
            tk_phase = ilt_pkg::PH_CMD_START;
          end
        end
        ilt_pkg::PH_CMD_START: begin
          tk_start = cur;
          tk_phase = ilt_pkg::PH_CMD;
          again = 1'b1;
        end
        ilt_pkg::PH_CMD: begin
          if (c == ilt_pkg::CH_SPACE) begin
            add_token(ilt_pkg::KIND_COMMAND, tk_start, cur - tk_start, 1'b0, 0, 0, 0, 1'b0);
            tk_phase = ilt_pkg::PH_PARAM_START;
          end
        end
        ilt_pkg::PH_PARAM_START: begin
          tk_start = cur;
          if (c == ilt_pkg::CH_COLON) tk_phase = ilt_pkg::PH_COLON;
          else if (c == ilt_pkg::CH_SPACE) close_param(cur, 0);
          else tk_phase = ilt_pkg::PH_PARAM;
        end
        ilt_pkg::PH_PARAM: begin
          if (c == ilt_pkg::CH_SPACE) begin
            close_param(tk_start, cur - tk_start);
            tk_phase = ilt_pkg::PH_PARAM_START;
          end
        end
        ilt_pkg::PH_COLON: tk_phase = ilt_pkg::PH_TRAILING;
        default: ;
      endcase
    end

    if (fin) begin
      stop = tk_pos;
      case (tk_phase)
        ilt_pkg::PH_KEY, ilt_pkg::PH_VALUE: close_tag(stop);
        ilt_pkg::PH_PREFIX:
          add_token(ilt_pkg::KIND_PREFIX, tk_start, stop - tk_start, 1'b0, 0, 0, 0, 1'b0);
        ilt_pkg::PH_CMD:
          add_token(ilt_pkg::KIND_COMMAND, tk_start, stop - tk_start, 1'b0, 0, 0, 0, 1'b0);
        ilt_pkg::PH_PARAM, ilt_pkg::PH_COLON: close_param(tk_start, stop - tk_start);
        ilt_pkg::PH_TRAILING: begin
          ts = after_pos(tk_start);
          add_token(ilt_pkg::KIND_TRAILING, ts, stop - ts, 1'b0, 0, 0, 0, 1'b0);
        end
        default: ;
      endcase
      add_token(ilt_pkg::KIND_EOL, 0, stop, 1'b0, 0, 0, tk_params, 1'b1);
      tk_phase = ilt_pkg::PH_LINE_START;
      tk_pos = 0;
      tk_start = 0;
      tk_vstart = 0;
      tk_has_val = 1'b0;
      tk_tags = 0;
      tk_params = 0;
      tk_ovf = 1'b0;
    end
  endfunction

  function automatic string rec_str(token_rec_t r);
    return $sformatf({"kind=%0d start=%0d len=%0d vp=%0d vstart=%0d vlen=%0d",
                      " idx=%0d ovf=%0d eol=%0d"},
                     r.kind, r.start, r.len, r.vp, r.vstart, r.vlen, r.idx, r.ovf, r.eol);
  endfunction

  function automatic void check_record();
    token_rec_t got;
    token_rec_t want;
    // out_tdata from bit 0: start, length, value flag, value start, value length,
    // index, overflow.
    got.kind   = ilt_pkg::kind_t'(out_tuser);
    got.start  = out_tdata[12:0];
    got.len    = out_tdata[26:13];
    got.vp     = out_tdata[27];
    got.vstart = out_tdata[40:28];
    got.vlen   = out_tdata[54:41];
    got.idx    = out_tdata[62:55];
    got.ovf    = out_tdata[63];
    got.eol    = out_tlast;
    if (expected_tokens.size() == 0) begin
      err_count++;
      if (err_count <= 10) $display("ERROR: record with nothing expected: %s", rec_str(got));
    end else begin
      want = expected_tokens.pop_front();
      if (got !== want) begin
        err_count++;
        if (err_count <= 10)
          $display("ERROR: record mismatch\n  expected %s\n  actual   %s",
                   rec_str(want), rec_str(got));
      end
    end
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 15);
    return $urandom_range(30, 100);
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      in_fire = 1'b0;
      quiet_cycles = 0;
    end else begin
      in_fire = in_tvalid && in_tready;
      if (out_tvalid && out_tready) check_record();
      if (in_fire) predict_tokens(in_tdata, in_tlast);
      if (in_fire || (out_tvalid && out_tready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_CYCLES) begin
        $display("irc_line_tokenizer_unit_tb NOT OK");
        $finish;
      end
    end
  end

  always @(negedge clk) begin
    if (rst_n && (!in_tvalid || in_fire)) begin
      if (tx_wait > 0) begin
        tx_wait--;
        in_tvalid <= 1'b0;
      end else if (feed_q.size() > 0) begin
        next_byte = feed_q.pop_front();
        in_tdata <= next_byte.data;
        in_tlast <= next_byte.last;
        in_tvalid <= 1'b1;
        tx_wait = tx_burst ? 0 : pick_gap();
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rst_n) begin
      if (rx_hold_req > 0) begin
        rx_stall = rx_hold_req;
        rx_hold_req = 0;
      end
      if (rx_stall > 0) begin
        rx_stall--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        if (!rx_burst) rx_stall = pick_gap();
      end
    end
  end

  task automatic add_text(string s);
    for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
  endtask

  task automatic add_word(int lo, int hi);
    int n;
    n = $urandom_range(lo, hi);
    repeat (n) begin
      if ($urandom_range(0, 99) < 4) line_buf.push_back(8'($urandom_range(0, 255)));
      else line_buf.push_back(word_chars[$urandom_range(0, word_chars.len() - 1)]);
    end
  endtask

  task automatic commit_line();
    line_byte_t item;
    for (int i = 0; i < line_buf.size(); i++) begin
      item.data = line_buf[i];
      item.last = (i == line_buf.size() - 1);
      feed_q.push_back(item);
    end
    line_buf.delete();
  endtask

  task automatic gen_message();
    int n;
    if ($urandom_range(0, 99) < 35) begin
      line_buf.push_back(ilt_pkg::CH_AT);
      n = $urandom_range(1, 4);
      for (int i = 0; i < n; i++) begin
        if (i > 0) line_buf.push_back(ilt_pkg::CH_SEMI);
        add_word(($urandom_range(0, 9) == 0) ? 0 : 1, 6);
        if ($urandom_range(0, 2) != 0) begin
          line_buf.push_back(ilt_pkg::CH_EQ);
          add_word(0, 8);
          if ($urandom_range(0, 5) == 0) begin
            line_buf.push_back(ilt_pkg::CH_EQ);
            add_word(0, 3);
          end
        end
      end
      line_buf.push_back(ilt_pkg::CH_SPACE);
    end
    if ($urandom_range(0, 99) < 40) begin
      line_buf.push_back(ilt_pkg::CH_COLON);
      add_word(1, 12);
      line_buf.push_back(ilt_pkg::CH_SPACE);
    end
    add_word(1, 8);
    n = $urandom_range(0, 5);
    repeat (n) begin
      line_buf.push_back(ilt_pkg::CH_SPACE);
      add_word(($urandom_range(0, 5) == 0) ? 0 : 1, 6);
    end
    if ($urandom_range(0, 99) < 45) begin
      line_buf.push_back(ilt_pkg::CH_SPACE);
      line_buf.push_back(ilt_pkg::CH_COLON);
      n = $urandom_range(0, 15);
      repeat (n) begin
        if ($urandom_range(0, 4) != 0) add_word(1, 1);
        else if ($urandom_range(0, 2) == 0) line_buf.push_back(ilt_pkg::CH_COLON);
        else line_buf.push_back(ilt_pkg::CH_SPACE);
      end
    end
  endtask

  task automatic wait_drained();
    while (feed_q.size() != 0 || in_tvalid || expected_tokens.size() != 0) @(posedge clk);
  endtask

  initial begin
    logic [7:0] specials[5];
    int r;
    int n;
    int batch_bytes;
    int keep;
    specials = '{ilt_pkg::CH_AT, ilt_pkg::CH_SPACE, ilt_pkg::CH_EQ, ilt_pkg::CH_SEMI,
                 ilt_pkg::CH_COLON};

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    add_text("@a=b;c;=v;;d=x=y :nick!u@h PRIVMSG #chan :hello world"); commit_line();
    add_text("@ CMD x"); commit_line();
    add_text("@k; CMD"); commit_line();
    add_text("@"); commit_line();
    add_text(":"); commit_line();
    add_text("CMD a  b"); commit_line();
    add_text("CMD  "); commit_line();
    add_text("CMD a :"); commit_line();
    add_text("CMD :"); commit_line();
    add_text("CMD ::"); commit_line();
    add_text("CMD a :trail ing: x"); commit_line();
    add_text("x"); commit_line();
    add_text(" "); commit_line();
    add_text("@a="); commit_line();
    add_text("@key"); commit_line();
    add_text(":pre"); commit_line();
    line_buf.push_back(8'h00); line_buf.push_back(8'hFF);
    line_buf.push_back(ilt_pkg::CH_SPACE); line_buf.push_back(8'h80);
    line_buf.push_back(8'h7F); commit_line();

    // Tag and parameter ordinals saturate past 255.
    line_buf.push_back(ilt_pkg::CH_AT);
    repeat (300) line_buf.push_back(ilt_pkg::CH_SEMI);
    add_text(" C"); commit_line();
    add_text("C");
    repeat (300) line_buf.push_back(ilt_pkg::CH_SPACE);
    commit_line();
    wait_drained();

    // Receiver holds off while the sender keeps the input busy.
    tx_burst = 1'b1;
    rx_hold_req = 300;
    repeat (8) begin
      add_text("CMD a b c d e f g h i j k");
      commit_line();
    end
    wait_drained();

    for (int b = 0; b < 4; b++) begin
      tx_burst = (b == 1);
      rx_burst = (b == 1) || (b == 2);
      batch_bytes = 0;
      while (batch_bytes < 220) begin
        r = $urandom_range(0, 99);
        if (r < 13) begin
          n = $urandom_range(1, 40);
          repeat (n) begin
            if ($urandom_range(0, 1) == 0) line_buf.push_back(specials[$urandom_range(0, 4)]);
            else line_buf.push_back(8'($urandom_range(0, 255)));
          end
        end else begin
          gen_message();
          if (r < 25) begin
            keep = $urandom_range(1, line_buf.size());
            while (line_buf.size() > keep) void'(line_buf.pop_back());
          end
        end
        batch_bytes += line_buf.size();
        commit_line();
      end
      wait_drained();
    end

    repeat (20) @(posedge clk);
    if (err_count == 0) begin
      $display("irc_line_tokenizer_unit_tb OK");
    end else begin
      $display("irc_line_tokenizer_unit_tb NOT OK");
    end
    $finish;
  end

endmodule
